FILE: src/i2cm_pkg.sv
// i2cm_pkg: shared types, command codes and constants for the I2C master core.
// No dependencies; every other file imports it.

package i2cm_pkg;

   localparam int TICKS_W     = 10;
   localparam int FUNC_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int SAMPLE_W    = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SEG_W       = 3;
   localparam int PHASE_W     = 5;
   localparam int BIT_W       = 3;

   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(10);
   localparam logic [BYTE_W-1:0]  MSB_MASK    = 8'h80;
   localparam logic [BIT_W-1:0]   LAST_BIT    = 3'd7;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WAITACK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PROBE   = 3'd5;

   // classified command held in the queue between front and back
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] data;
      logic              give_ack;
      logic [BYTE_W-1:0] read_data;
      logic              no_ack;
   } desc_type;

   // line segment being played out by the back end
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_STOP,
      ST_WRITE,
      ST_WAITACK,
      ST_READ,
      ST_ACKTAIL,
      ST_NACKTAIL
   } state_type;

endpackage

FILE: src/i2cm_req_if.sv
// i2cm_req_if: command channel (valid/ready plus command payload).
// Depends on i2cm_pkg.

interface i2cm_req_if import i2cm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [BYTE_W-1:0]   data_byte;
   logic                give_ack;
   logic [SAMPLE_W-1:0] sda_samples;

   modport source (output valid, func, data_byte, give_ack, sda_samples, input ready);
   modport sink   (input valid, func, data_byte, give_ack, sda_samples, output ready);
endinterface

FILE: src/i2cm_rsp_if.sv
// i2cm_rsp_if: line phase channel (valid/ready plus one SCL/SDA phase).
// Depends on i2cm_pkg.

interface i2cm_rsp_if import i2cm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              scl_level;
   logic              sda_level;
   logic              last;
   logic [BYTE_W-1:0] read_data;
   logic              no_ack;

   modport source  (output valid, scl_level, sda_level, last, read_data, no_ack,
                    input ready);
   modport sink    (input valid, scl_level, sda_level, last, read_data, no_ack,
                    output ready);
   modport monitor (input valid, ready, scl_level, sda_level, last, read_data, no_ack);
endinterface

FILE: src/i2cm_front.sv
// i2cm_front: takes commands, drops undefined codes, builds queue descriptors.
// Depends on i2cm_pkg and i2cm_req_if.

module i2cm_front import i2cm_pkg::*; (
   i2cm_req_if.sink req_ch,
   input  logic     q_full,
   output logic     push,
   output desc_type desc
);

   logic func_ok;

   assign req_ch.ready = !q_full;

   always_comb begin
      func_ok        = 1'b1;
      desc.func      = req_ch.func;
      desc.data      = req_ch.data_byte;
      desc.give_ack  = req_ch.give_ack;
      desc.read_data = '0;
      desc.no_ack    = 1'b0;
      unique case (req_ch.func) inside
         FUNC_START, FUNC_STOP, FUNC_WRITE: begin
         end
         FUNC_WAITACK: begin
            desc.no_ack = req_ch.sda_samples[SAMPLE_W-1];
         end
         FUNC_READ: begin
            desc.read_data = req_ch.sda_samples[SAMPLE_W-1:1];
         end
         FUNC_PROBE: begin
            // address with the R/W bit forced to write
            desc.data   = {req_ch.data_byte[BYTE_W-1:1], 1'b0};
            desc.no_ack = req_ch.sda_samples[SAMPLE_W-1];
         end
         default: begin
            func_ok = 1'b0;
         end
      endcase
   end

   assign push = req_ch.valid && req_ch.ready && func_ok;

endmodule

FILE: src/i2cm_queue.sv
// i2cm_queue: short descriptor FIFO between front and back.
// Depends on i2cm_pkg.

module i2cm_queue import i2cm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output desc_type head
);

   desc_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: src/i2cm_back.sv
// i2cm_back: segment sequencer that plays each command out as line phases,
// paces them by the half-period timer and drives the phase output register.
// Depends on i2cm_pkg and i2cm_rsp_if.

module i2cm_back import i2cm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TICKS_W-1:0] ticks,
   input  logic               q_valid,
   input  desc_type           head,
   output logic               pop,
   i2cm_rsp_if.source         rsp_ch
);

   // segment list of each command; ST_IDLE past the end
   function automatic state_type seg_list(input logic [FUNC_W-1:0] func,
                                          input logic ack,
                                          input logic [SEG_W-1:0] idx);
      state_type r;
      r = ST_IDLE;
      case (func)
         FUNC_START:   r = (idx == '0) ? ST_START   : ST_IDLE;
         FUNC_STOP:    r = (idx == '0) ? ST_STOP    : ST_IDLE;
         FUNC_WRITE:   r = (idx == '0) ? ST_WRITE   : ST_IDLE;
         FUNC_WAITACK: r = (idx == '0) ? ST_WAITACK : ST_IDLE;
         FUNC_READ: begin
            if (idx == 3'd0) begin
               r = ST_READ;
            end else if (idx == 3'd1) begin
               r = ack ? ST_ACKTAIL : ST_NACKTAIL;
            end
         end
         FUNC_PROBE: begin
            case (idx)
               3'd0:    r = ST_STOP;
               3'd1:    r = ST_START;
               3'd2:    r = ST_WRITE;
               3'd3:    r = ST_WAITACK;
               3'd4:    r = ST_STOP;
               default: r = ST_IDLE;
            endcase
         end
         default: r = ST_IDLE;
      endcase
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [PHASE_W-1:0]   ph_ff, ph_in;
   logic [1:0]           tri_ff, tri_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   desc_type             cur_ff, cur_in;
   logic [TICKS_W-1:0]   timer_ff, timer_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_scl_ff, out_sda_ff, out_last_ff, out_nak_ff;
   logic [BYTE_W-1:0]    out_rd_ff;

   logic                 emit, ph_last, seg_end, cmd_end;
   logic                 scl, sda;
   state_type            next_seg;

   // ---- phase outputs and segment end ----
   always_comb begin
      scl     = 1'b0;
      sda     = 1'b1;
      ph_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_START: begin
            scl     = (ph_ff != 5'd2);
            sda     = (ph_ff == 5'd0);
            ph_last = (ph_ff == 5'd2);
         end
         ST_STOP: begin
            scl     = 1'b1;
            sda     = (ph_ff == 5'd1);
            ph_last = (ph_ff == 5'd1);
         end
         ST_WRITE: begin
            // three phases per bit; SDA released in the last phase of the last bit
            scl     = (tri_ff == 2'd1);
            sda     = ((tri_ff == 2'd2) && (bit_ff == LAST_BIT)) ? 1'b1
                      : |(shift_ff & MSB_MASK);
            ph_last = (tri_ff == 2'd2) && (bit_ff == LAST_BIT);
         end
         ST_WAITACK: begin
            scl     = (ph_ff == 5'd1);
            ph_last = (ph_ff == 5'd2);
         end
         ST_READ: begin
            scl     = !ph_ff[0];
            ph_last = (ph_ff == 5'd15);
         end
         ST_ACKTAIL: begin
            scl     = (ph_ff == 5'd1);
            sda     = (ph_ff == 5'd3);
            ph_last = (ph_ff == 5'd3);
         end
         ST_NACKTAIL: begin
            scl     = (ph_ff == 5'd1);
            ph_last = (ph_ff == 5'd2);
         end
         default: begin
         end
      endcase
   end

   assign emit     = (state_ff != ST_IDLE) && (timer_ff == '0)
                     && (!out_valid_ff || rsp_ch.ready);
   assign seg_end  = emit && ph_last;
   assign next_seg = seg_list(cur_ff.func, cur_ff.give_ack, seg_ff + 1'b1);
   assign cmd_end  = seg_end && (next_seg == ST_IDLE);
   assign pop      = ((state_ff == ST_IDLE) || cmd_end) && q_valid;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      ph_in    = ph_ff;
      tri_in   = tri_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      cur_in   = cur_ff;
      if (pop) begin
         state_in = seg_list(head.func, head.give_ack, '0);
         seg_in   = '0;
         ph_in    = '0;
         tri_in   = '0;
         bit_in   = '0;
         shift_in = head.data;
         cur_in   = head;
      end else if (seg_end) begin
         state_in = next_seg;
         seg_in   = seg_ff + 1'b1;
         ph_in    = '0;
         tri_in   = '0;
         bit_in   = '0;
      end else if (emit) begin
         ph_in = ph_ff + 1'b1;
         if (tri_ff == 2'd2) begin
            tri_in   = '0;
            bit_in   = bit_ff + 1'b1;
            shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
         end else begin
            tri_in = tri_ff + 1'b1;
         end
      end
   end

   // ---- phase hold timer and output register ----
   always_comb begin
      timer_in = timer_ff;
      if (emit) begin
         timer_in = (ticks == '0) ? '0 : ticks - 1'b1;
      end else if (timer_ff != '0) begin
         timer_in = timer_ff - 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= '0;
         ph_ff        <= '0;
         tri_ff       <= '0;
         bit_ff       <= '0;
         timer_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         ph_ff        <= ph_in;
         tri_ff       <= tri_in;
         bit_ff       <= bit_in;
         timer_ff     <= timer_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cur_ff   <= cur_in;
      if (emit) begin
         out_scl_ff  <= scl;
         out_sda_ff  <= sda;
         out_last_ff <= cmd_end;
         out_rd_ff   <= cmd_end ? cur_ff.read_data : '0;
         out_nak_ff  <= cmd_end && cur_ff.no_ack;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.scl_level = out_scl_ff;
   assign rsp_ch.sda_level = out_sda_ff;
   assign rsp_ch.last      = out_last_ff;
   assign rsp_ch.read_data = out_rd_ff;
   assign rsp_ch.no_ack    = out_nak_ff;

endmodule

FILE: src/i2c_bit_level_master_core.sv
// I2C bit-level master core: command channel in, line phase channel out.
// Depends on i2cm_pkg, i2cm_req_if, i2cm_rsp_if, i2cm_front, i2cm_queue, i2cm_back.
//
// Usage:
//   req_ch carries one command per transfer: func (start, stop, write byte,
//   wait ack, read byte, probe), data_byte, give_ack and the SDA samples
//   seen on the bus. Undefined func codes are taken and dropped.
//   rsp_ch carries one SCL/SDA line phase per transfer; last marks the
//   final phase of a command, which also carries read_data and no_ack.
//   Phase counts: start 3, stop 2, write 24, wait ack 3, read 20 (ACK) or
//   19 (NACK), probe 34.
//   csr_write_en/csr_write_data set half_period_ticks, which sets how long
//   each phase is held; write it only while the core is idle.
// Command path: when the core is idle, a command taken on req_ch is written
//   into the queue, popped into the sequencer, then its first phase is registered.
// Pacing: phases are spaced by the phase hold timer in the back end, loaded
//   from half_period_ticks, and the next queued command follows without a gap.
// Reset: clears the queue, the sequencer and the output register; the
//   half-period register returns to 10.
// Stalls: a phase waits in the output register while rsp_ch.ready is low;
//   up to two further commands are taken into the queue meanwhile.

module i2c_bit_level_master_core import i2cm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   i2cm_req_if.sink           req_ch,
   i2cm_rsp_if.source         rsp_ch,
   input  logic               csr_write_en,
   input  logic [TICKS_W-1:0] csr_write_data
);

   logic [TICKS_W-1:0] ticks_ff;

   logic     q_full, q_not_empty, q_push, q_pop;
   desc_type push_desc, head_desc;

   // half-period register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else if (csr_write_en) begin
         ticks_ff <= csr_write_data;
      end
   end

   // front: accept and classify commands
   i2cm_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (q_push),
      .desc   (push_desc)
   );

   // decoupling queue
   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_desc)
   );

   // back: sequence line phases
   i2cm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .ticks   (ticks_ff),
      .q_valid (q_not_empty),
      .head    (head_desc),
      .pop     (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: src/i2cm_checker.sv
// i2cm_checker: port-level assertions on the phase channel, bound to the top.
// Depends on i2cm_pkg and i2c_bit_level_master_core.

module i2cm_checker import i2cm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_scl_level,
   input logic              rsp_sda_level,
   input logic              rsp_last,
   input logic [BYTE_W-1:0] rsp_read_data,
   input logic              rsp_no_ack
);

   // a stalled phase holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_level) && $stable(rsp_last))
      else $error("phase changed while stalled");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("phase valid after reset");

   // status fields only on the final phase
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_read_data == '0 && !rsp_no_ack)
      else $error("status on non-final phase");

   // a command can end with SCL high only as a stop, with SDA released
   a_end_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_scl_level |-> rsp_sda_level)
      else $error("final phase with SCL high is not a stop");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_scl_level (rsp_ch.scl_level),
   .rsp_sda_level (rsp_ch.sda_level),
   .rsp_last      (rsp_ch.last),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_no_ack    (rsp_ch.no_ack)
);
